### design/ccg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccg_pkg: shared types and constants of the color gradient sampler
// Node table geometry, command codes, beat payloads and divider link types.
// ----------------------------------------------------------------------------
package ccg_pkg;

  localparam int unsigned MaxNodes = 64;
  localparam int unsigned IdxW     = $clog2(MaxNodes);
  localparam int unsigned CntW     = $clog2(MaxNodes + 1);
  localparam int unsigned ChanW    = 16;
  localparam int unsigned SpanW    = 24;
  localparam int unsigned PosW     = 32;
  localparam int unsigned TotalW   = SpanW + IdxW;
  localparam int unsigned DivNumW  = ChanW + SpanW;
  localparam int unsigned DivDenW  = TotalW;
  localparam int unsigned DivCntW  = $clog2(DivNumW + 1);
  localparam int unsigned NodeW    = 3 * ChanW + SpanW;

  localparam logic [ChanW-1:0] FullChan = {ChanW{1'b1}};

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_SAMPLE = 2'd2
  } cmd_e;

  typedef struct packed {
    cmd_e             command;
    logic [ChanW-1:0] node_red;
    logic [ChanW-1:0] node_green;
    logic [ChanW-1:0] node_blue;
    logic [SpanW-1:0] node_span;
    logic [PosW-1:0]  position;
  } in_beat_t;

  typedef struct packed {
    logic [ChanW-1:0] out_red;
    logic [ChanW-1:0] out_green;
    logic [ChanW-1:0] out_blue;
    logic             no_segment;
  } out_beat_t;

  typedef struct packed {
    logic               start;
    logic [DivNumW-1:0] dividend;
    logic [DivDenW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DivNumW-1:0] quotient;
    logic [DivDenW-1:0] remainder;
  } div_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MOD,
    S_RD,
    S_CMP,
    S_RDN,
    S_LDN,
    S_MUL,
    S_DIVGO,
    S_DIV,
    S_OUT
  } state_e;

endpackage

### design/cyclic_color_gradient_sampler_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cyclic_color_gradient_sampler_core: cyclic piecewise-linear color gradient
// Node table with clear/append, and a sampler that wraps the position,
// walks the segments and blends the channel colors through one divider.
// ----------------------------------------------------------------------------
//  channel | signals                         | payload
//  --------+---------------------------------+---------------------------
//  in      | in_valid_i / in_ready_o         | ccg_pkg::in_beat_t  (cmd)
//  out     | out_valid_o / out_ready_i       | ccg_pkg::out_beat_t (sample)
//
//  Clear and append produce no beat.
//  A sample first wraps the position (40-bit serial divide), then walks the
//  nodes with one read and one compare per node walked, then blends the
//  three channels, each with a multiply and a serial divide.
//  An empty table or zero total span skips straight to the no-segment answer.
//  Reset clears the node count and total span; the table itself is not
//  cleared. A stalled output holds its beat; in_ready_o drops while busy.
// ----------------------------------------------------------------------------
module cyclic_color_gradient_sampler_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ccg_pkg::in_beat_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ccg_pkg::out_beat_t  out_data_o
);

  ccg_pkg::state_e state_q, state_d;

  logic [ccg_pkg::NodeW-1:0] mem [ccg_pkg::MaxNodes];
  logic [ccg_pkg::NodeW-1:0] rd_data_q;
  logic [ccg_pkg::IdxW-1:0]  rd_addr;
  logic                      wr_en;

  logic [ccg_pkg::CntW-1:0]   count_q, count_d;
  logic [ccg_pkg::TotalW-1:0] total_q, total_d;
  logic [ccg_pkg::TotalW-1:0] pos_q, pos_d;
  logic [ccg_pkg::TotalW-1:0] start_q, start_d;
  logic [ccg_pkg::IdxW-1:0]   idx_q, idx_d;
  logic [ccg_pkg::IdxW-1:0]   nxt_q, nxt_d;
  logic [ccg_pkg::SpanW-1:0]  span_q, span_d;
  logic [ccg_pkg::SpanW-1:0]  off_q, off_d;
  logic [ccg_pkg::ChanW-1:0]  cur_q [3];
  logic [ccg_pkg::ChanW-1:0]  cur_d [3];
  logic [ccg_pkg::ChanW-1:0]  nc_q [3];
  logic [ccg_pkg::ChanW-1:0]  nc_d [3];
  logic [ccg_pkg::ChanW-1:0]  res_q [3];
  logic [ccg_pkg::ChanW-1:0]  res_d [3];
  logic                       flag_q, flag_d;
  logic [1:0]                 ch_q, ch_d;
  logic [ccg_pkg::DivNumW-1:0] prod_q, prod_d;
  logic                       neg_q, neg_d;
  logic                       out_valid_q, out_valid_d;
  ccg_pkg::out_beat_t         out_q, out_d;

  ccg_pkg::div_req_t div_req;
  ccg_pkg::div_rsp_t div_rsp;

  logic                       in_fire;
  logic                       tbl_empty;
  logic [ccg_pkg::SpanW-1:0]  rd_span;
  logic [ccg_pkg::TotalW:0]   seg_end;
  logic                       hit;
  logic [ccg_pkg::CntW-1:0]   idx_inc;
  logic                       out_free;
  logic [ccg_pkg::ChanW-1:0]  blend;

  assign in_ready_o = (state_q == ccg_pkg::S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign tbl_empty  = (count_q == '0) || (total_q == '0);
  assign rd_span    = rd_data_q[ccg_pkg::SpanW-1:0];
  assign seg_end    = {1'b0, start_q} + (ccg_pkg::TotalW + 1)'(rd_span);
  assign hit        = ({1'b0, pos_q} < seg_end);
  assign idx_inc    = {1'b0, idx_q} + 1'b1;
  assign out_free   = !out_valid_q || out_ready_i;
  assign blend      = neg_q ? cur_q[0] - div_rsp.quotient[ccg_pkg::ChanW-1:0]
                            : cur_q[0] + div_rsp.quotient[ccg_pkg::ChanW-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ccg_pkg::S_IDLE: begin
        if (in_fire && in_data_i.command == ccg_pkg::CMD_SAMPLE) begin
          state_d = tbl_empty ? ccg_pkg::S_OUT : ccg_pkg::S_MOD;
        end
      end
      ccg_pkg::S_MOD:   if (div_rsp.done) state_d = ccg_pkg::S_RD;
      ccg_pkg::S_RD:    state_d = ccg_pkg::S_CMP;
      ccg_pkg::S_CMP: begin
        if (hit) begin
          state_d = ccg_pkg::S_RDN;
        end else if (idx_inc == count_q) begin
          state_d = ccg_pkg::S_OUT;
        end else begin
          state_d = ccg_pkg::S_RD;
        end
      end
      ccg_pkg::S_RDN:   state_d = ccg_pkg::S_LDN;
      ccg_pkg::S_LDN:   state_d = ccg_pkg::S_MUL;
      ccg_pkg::S_MUL:   state_d = ccg_pkg::S_DIVGO;
      ccg_pkg::S_DIVGO: state_d = ccg_pkg::S_DIV;
      ccg_pkg::S_DIV: begin
        if (div_rsp.done) state_d = (ch_q == 2'd2) ? ccg_pkg::S_OUT : ccg_pkg::S_MUL;
      end
      ccg_pkg::S_OUT:   if (out_free) state_d = ccg_pkg::S_IDLE;
      default:          state_d = ccg_pkg::S_IDLE;
    endcase
  end

  // divider requests and table access
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = prod_q;
    div_req.divisor  = ccg_pkg::DivDenW'(span_q);
    wr_en            = 1'b0;
    rd_addr          = idx_q;
    unique case (state_q)
      ccg_pkg::S_IDLE: begin
        div_req.dividend = ccg_pkg::DivNumW'(in_data_i.position);
        div_req.divisor  = total_q;
        div_req.start    = in_fire && (in_data_i.command == ccg_pkg::CMD_SAMPLE) &&
                           !tbl_empty;
        wr_en            = in_fire && (in_data_i.command == ccg_pkg::CMD_APPEND) &&
                           (count_q < ccg_pkg::CntW'(ccg_pkg::MaxNodes));
      end
      ccg_pkg::S_DIVGO: div_req.start = 1'b1;
      ccg_pkg::S_RDN:   rd_addr = nxt_q;
      default: ;
    endcase
  end

  // datapath
  always_comb begin
    count_d     = count_q;
    total_d     = total_q;
    pos_d       = pos_q;
    start_d     = start_q;
    idx_d       = idx_q;
    nxt_d       = nxt_q;
    span_d      = span_q;
    off_d       = off_q;
    cur_d       = cur_q;
    nc_d        = nc_q;
    res_d       = res_q;
    flag_d      = flag_q;
    ch_d        = ch_q;
    prod_d      = prod_q;
    neg_d       = neg_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    unique case (state_q)
      ccg_pkg::S_IDLE: begin
        if (in_fire) begin
          case (in_data_i.command)
            ccg_pkg::CMD_CLEAR: begin
              count_d = '0;
              total_d = '0;
            end
            ccg_pkg::CMD_APPEND: begin
              if (wr_en) begin
                count_d = count_q + 1'b1;
                total_d = total_q + ccg_pkg::TotalW'(in_data_i.node_span);
              end
            end
            ccg_pkg::CMD_SAMPLE: begin
              // preload the no-segment answer
              res_d[0] = ccg_pkg::FullChan;
              res_d[1] = '0;
              res_d[2] = '0;
              flag_d   = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ccg_pkg::S_MOD: begin
        pos_d   = div_rsp.remainder;
        start_d = '0;
        idx_d   = '0;
      end
      ccg_pkg::S_CMP: begin
        if (hit) begin
          span_d   = rd_span;
          off_d    = ccg_pkg::SpanW'(pos_q - start_q);
          cur_d[0] = rd_data_q[ccg_pkg::NodeW-1 -: ccg_pkg::ChanW];
          cur_d[1] = rd_data_q[ccg_pkg::NodeW-1-ccg_pkg::ChanW -: ccg_pkg::ChanW];
          cur_d[2] = rd_data_q[ccg_pkg::SpanW +: ccg_pkg::ChanW];
          nxt_d    = (idx_inc < count_q) ? idx_inc[ccg_pkg::IdxW-1:0] : '0;
        end else begin
          start_d = seg_end[ccg_pkg::TotalW-1:0];
          idx_d   = idx_inc[ccg_pkg::IdxW-1:0];
        end
      end
      ccg_pkg::S_LDN: begin
        nc_d[0] = rd_data_q[ccg_pkg::NodeW-1 -: ccg_pkg::ChanW];
        nc_d[1] = rd_data_q[ccg_pkg::NodeW-1-ccg_pkg::ChanW -: ccg_pkg::ChanW];
        nc_d[2] = rd_data_q[ccg_pkg::SpanW +: ccg_pkg::ChanW];
        ch_d    = '0;
        flag_d  = 1'b0;
      end
      ccg_pkg::S_MUL: begin
        neg_d  = nc_q[0] < cur_q[0];
        prod_d = ccg_pkg::DivNumW'(neg_q ? cur_q[0] - nc_q[0] : nc_q[0] - cur_q[0]);
        if (nc_q[0] < cur_q[0]) begin
          prod_d = ccg_pkg::DivNumW'(cur_q[0] - nc_q[0]) * ccg_pkg::DivNumW'(off_q);
        end else begin
          prod_d = ccg_pkg::DivNumW'(nc_q[0] - cur_q[0]) * ccg_pkg::DivNumW'(off_q);
        end
      end
      ccg_pkg::S_DIV: begin
        if (div_rsp.done) begin
          // shift the finished channel in, advance to the next one
          res_d[0] = res_q[1];
          res_d[1] = res_q[2];
          res_d[2] = blend;
          cur_d[0] = cur_q[1];
          cur_d[1] = cur_q[2];
          cur_d[2] = cur_q[0];
          nc_d[0]  = nc_q[1];
          nc_d[1]  = nc_q[2];
          nc_d[2]  = nc_q[0];
          ch_d     = ch_q + 1'b1;
        end
      end
      ccg_pkg::S_OUT: begin
        if (out_free) begin
          out_valid_d      = 1'b1;
          out_d.out_red    = res_q[0];
          out_d.out_green  = res_q[1];
          out_d.out_blue   = res_q[2];
          out_d.no_segment = flag_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ccg_pkg::S_IDLE;
      count_q     <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    start_q <= start_d;
    idx_q   <= idx_d;
    nxt_q   <= nxt_d;
    span_q  <= span_d;
    off_q   <= off_d;
    cur_q   <= cur_d;
    nc_q    <= nc_d;
    res_q   <= res_d;
    flag_q  <= flag_d;
    ch_q    <= ch_d;
    prod_q  <= prod_d;
    neg_q   <= neg_d;
    out_q   <= out_d;
  end

  // node table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[count_q[ccg_pkg::IdxW-1:0]] <= {in_data_i.node_red, in_data_i.node_green,
                                          in_data_i.node_blue, in_data_i.node_span};
    end
    rd_data_q <= mem[rd_addr];
  end

  ccg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### design/ccg_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccg_div: bit-serial restoring divider
// One quotient bit per cycle; done pulses together with the final quotient and remainder.
// ----------------------------------------------------------------------------
module ccg_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ccg_pkg::div_req_t req_i,
  output ccg_pkg::div_rsp_t rsp_o
);

  logic [ccg_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic [ccg_pkg::DivNumW-1:0] quo_q, quo_d;
  logic [ccg_pkg::DivDenW-1:0] rem_q, rem_d;
  logic [ccg_pkg::DivDenW-1:0] den_q, den_d;
  logic                        done_q, done_d;
  logic [ccg_pkg::DivDenW:0]   trial;
  logic [ccg_pkg::DivDenW+1:0] diff;
  logic                        borrow;

  assign trial  = {rem_q, quo_q[ccg_pkg::DivNumW-1]};
  assign diff   = {1'b0, trial} - {2'b00, den_q};
  assign borrow = diff[ccg_pkg::DivDenW+1];

  always_comb begin
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    done_d = 1'b0;
    if (req_i.start) begin
      cnt_d = ccg_pkg::DivCntW'(ccg_pkg::DivNumW);
      quo_d = req_i.dividend;
      rem_d = '0;
      den_d = req_i.divisor;
    end else if (cnt_q != '0) begin
      // restore on borrow, keep the difference otherwise
      rem_d  = borrow ? trial[ccg_pkg::DivDenW-1:0] : diff[ccg_pkg::DivDenW-1:0];
      quo_d  = {quo_q[ccg_pkg::DivNumW-2:0], ~borrow};
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == ccg_pkg::DivCntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

### tb/tb_cyclic_color_gradient_sampler_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cyclic_color_gradient_sampler_core: self-checking bench of the sampler
// Directed table of commands, then random gradient programs (usually a clear, a run of
// appends, a burst of samples) with idle bursts on both sides, a long output
// hold and a full drain. Every sample beat is checked against a fixed expected
// color or a model built on a bench-side copy of the node table.
// ----------------------------------------------------------------------------
module tb_cyclic_color_gradient_sampler_core;

  localparam int unsigned CycleLimit  = 2000000;
  localparam int unsigned ItemTarget  = 1200;
  localparam int unsigned QuietFrom   = 1050;
  localparam int unsigned LongHold    = 600;
  localparam int unsigned DrainCycles = 400;
  localparam logic [1:0]  CmdIgnored  = 2'd3;

  localparam ccg_pkg::out_beat_t NoSegColor =
    ccg_pkg::out_beat_t'({ccg_pkg::FullChan, 16'h0000, 16'h0000, 1'b1});

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  ccg_pkg::in_beat_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  ccg_pkg::out_beat_t out_data;

  // bench copy of the gradient
  logic [ccg_pkg::ChanW-1:0] tbl_red [ccg_pkg::MaxNodes];
  logic [ccg_pkg::ChanW-1:0] tbl_grn [ccg_pkg::MaxNodes];
  logic [ccg_pkg::ChanW-1:0] tbl_blu [ccg_pkg::MaxNodes];
  logic [ccg_pkg::SpanW-1:0] tbl_span [ccg_pkg::MaxNodes];
  int unsigned               tbl_count = 0;
  longint unsigned           tbl_total = 0;

  ccg_pkg::out_beat_t pending_colors[$];
  int unsigned        mismatches = 0;
  int unsigned        cycles = 0;
  bit                 tx_idle = 1'b1;
  bit                 rx_idle = 1'b1;
  bit                 hold_output = 1'b0;

  ccg_pkg::in_beat_t  dir_beats[$];
  bit                 dir_typed[$];
  ccg_pkg::out_beat_t dir_want[$];

  cyclic_color_gradient_sampler_core uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [ccg_pkg::ChanW-1:0] blend_chan(logic [ccg_pkg::ChanW-1:0] from_c,
                                                           logic [ccg_pkg::ChanW-1:0] to_c,
                                                           longint unsigned offset,
                                                           longint unsigned span);
    longint unsigned lo, hi, step;
    lo = 64'(from_c);
    hi = 64'(to_c);
    if (hi >= lo) begin
      step = (hi - lo) * offset / span;
      lo = lo + step;
    end else begin
      step = (lo - hi) * offset / span;
      lo = lo - step;
    end
    return lo[ccg_pkg::ChanW-1:0];
  endfunction

  function automatic ccg_pkg::out_beat_t gradient_color(logic [ccg_pkg::PosW-1:0] position);
    ccg_pkg::out_beat_t res;
    longint unsigned    pos, seg_start, seg_end, offset;
    int unsigned        i, hit, nxt;
    bit                 found;
    res = NoSegColor;
    if (tbl_count == 0 || tbl_total == 0) return res;
    pos = 64'(position);
    pos = pos % tbl_total;
    seg_start = 0;
    found = 1'b0;
    hit = 0;
    // zero-span segments are empty and never hit
    for (i = 0; i < tbl_count && !found; i++) begin
      seg_end = seg_start + 64'(tbl_span[i]);
      if (pos >= seg_start && pos < seg_end) begin
        found = 1'b1;
        hit = i;
      end else begin
        seg_start = seg_end;
      end
    end
    if (!found) return res;
    nxt = (hit + 1 < tbl_count) ? hit + 1 : 0;
    offset = pos - seg_start;
    res.out_red    = blend_chan(tbl_red[hit], tbl_red[nxt], offset, 64'(tbl_span[hit]));
    res.out_green  = blend_chan(tbl_grn[hit], tbl_grn[nxt], offset, 64'(tbl_span[hit]));
    res.out_blue   = blend_chan(tbl_blu[hit], tbl_blu[nxt], offset, 64'(tbl_span[hit]));
    res.no_segment = 1'b0;
    return res;
  endfunction

  function automatic logic [ccg_pkg::ChanW-1:0] pick_chan();
    case ($urandom_range(0, 6))
      0:       return '0;
      1:       return ccg_pkg::FullChan;
      default: return ccg_pkg::ChanW'($urandom);
    endcase
  endfunction

  function automatic ccg_pkg::in_beat_t noisy_beat(ccg_pkg::cmd_e cmd);
    ccg_pkg::in_beat_t b;
    b.command    = cmd;
    b.node_red   = ccg_pkg::ChanW'($urandom);
    b.node_green = ccg_pkg::ChanW'($urandom);
    b.node_blue  = ccg_pkg::ChanW'($urandom);
    b.node_span  = ccg_pkg::SpanW'($urandom);
    b.position   = $urandom;
    return b;
  endfunction

  task automatic add_row(input logic [1:0] cmd, input logic [ccg_pkg::ChanW-1:0] r,
                         input logic [ccg_pkg::ChanW-1:0] g,
                         input logic [ccg_pkg::ChanW-1:0] b,
                         input logic [ccg_pkg::SpanW-1:0] span,
                         input logic [ccg_pkg::PosW-1:0] pos,
                         input bit typed, input ccg_pkg::out_beat_t want);
    ccg_pkg::in_beat_t beat;
    beat.command    = ccg_pkg::cmd_e'(cmd);
    beat.node_red   = r;
    beat.node_green = g;
    beat.node_blue  = b;
    beat.node_span  = span;
    beat.position   = pos;
    dir_beats.insert(dir_beats.size(), beat);
    dir_typed.insert(dir_typed.size(), typed);
    dir_want.insert(dir_want.size(), want);
  endtask

  // Drive one command beat, hold it until taken, then update the table copy or queue the expected color.
  task automatic send_cmd(input ccg_pkg::in_beat_t beat, input bit typed,
                          input ccg_pkg::out_beat_t want);
    int unsigned gap;
    if (tx_idle && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
    case (beat.command)
      ccg_pkg::CMD_CLEAR: begin
        tbl_count = 0;
        tbl_total = 0;
      end
      ccg_pkg::CMD_APPEND: begin
        if (tbl_count < ccg_pkg::MaxNodes) begin
          tbl_red[tbl_count]  = beat.node_red;
          tbl_grn[tbl_count]  = beat.node_green;
          tbl_blu[tbl_count]  = beat.node_blue;
          tbl_span[tbl_count] = beat.node_span;
          tbl_total += 64'(beat.node_span);
          tbl_count++;
        end
      end
      ccg_pkg::CMD_SAMPLE:
        pending_colors.insert(pending_colors.size(),
                              typed ? want : gradient_color(beat.position));
      default: ;
    endcase
  endtask

  task automatic check_color(input ccg_pkg::out_beat_t got);
    ccg_pkg::out_beat_t want;
    if (pending_colors.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected beat r=%h g=%h b=%h ns=%b", $realtime,
                 got.out_red, got.out_green, got.out_blue, got.no_segment);
      return;
    end
    want = pending_colors.pop_front();
    if (got.out_red !== want.out_red || got.out_green !== want.out_green ||
        got.out_blue !== want.out_blue || got.no_segment !== want.no_segment) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: color mismatch exp r=%h g=%h b=%h ns=%b act r=%h g=%h b=%h ns=%b",
                 $realtime, want.out_red, want.out_green, want.out_blue, want.no_segment,
                 got.out_red, got.out_green, got.out_blue, got.no_segment);
    end
  endtask

  // Output side: check each taken beat, then pick ready for the next cycle.
  initial begin
    int unsigned stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) check_color(out_data);
      if (stall != 0) begin
        stall--;
        out_ready <= 1'b0;
      end else if (hold_output) begin
        hold_output = 1'b0;
        stall = LongHold - 1;
        out_ready <= 1'b0;
      end else if (rx_idle && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(0, 6);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    ccg_pkg::in_beat_t  beat;
    int unsigned        items, seq, n, k, j, r, tot32;
    longint unsigned    seg_start;
    ccg_pkg::out_beat_t none;
    none = '0;

    add_row(ccg_pkg::CMD_SAMPLE, 16'h0, 16'h0, 16'h0, 24'h0, 32'h0, 1'b1, NoSegColor);
    add_row(ccg_pkg::CMD_SAMPLE, 16'h0, 16'h0, 16'h0, 24'h0, 32'hFFFF_FFFF, 1'b1, NoSegColor);
    add_row(ccg_pkg::CMD_APPEND, 16'h1234, 16'h8000, 16'hFFFF, 24'h0, 32'h0, 1'b0, none);
    add_row(ccg_pkg::CMD_SAMPLE, 16'h0, 16'h0, 16'h0, 24'h0, 32'h0, 1'b1, NoSegColor);
    add_row(ccg_pkg::CMD_APPEND, 16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFF_FFFF, 32'h0, 1'b0, none);
    add_row(ccg_pkg::CMD_APPEND, 16'h0, 16'h0, 16'h0, 24'h01_0000, 32'h0, 1'b0, none);
    add_row(ccg_pkg::CMD_SAMPLE, 16'h0, 16'h0, 16'h0, 24'h0, 32'h0, 1'b1,
            ccg_pkg::out_beat_t'({ccg_pkg::FullChan, ccg_pkg::FullChan,
                                  ccg_pkg::FullChan, 1'b0}));
    add_row(ccg_pkg::CMD_SAMPLE, 16'h0, 16'h0, 16'h0, 24'h0, 32'h00FF_FFFE, 1'b0, none);
    add_row(ccg_pkg::CMD_SAMPLE, 16'h0, 16'h0, 16'h0, 24'h0, 32'h00FF_FFFF, 1'b1, '0);
    // last node blends back to the zero-span first node
    add_row(ccg_pkg::CMD_SAMPLE, 16'h0, 16'h0, 16'h0, 24'h0, 32'h0100_FFFE, 1'b0, none);
    add_row(ccg_pkg::CMD_SAMPLE, 16'h0, 16'h0, 16'h0, 24'h0, 32'h0100_FFFF, 1'b1,
            ccg_pkg::out_beat_t'({ccg_pkg::FullChan, ccg_pkg::FullChan,
                                  ccg_pkg::FullChan, 1'b0}));
    add_row(ccg_pkg::CMD_SAMPLE, 16'h0, 16'h0, 16'h0, 24'h0, 32'hFFFF_FFFF, 1'b0, none);
    add_row(CmdIgnored, 16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFF_FFFF, 32'hFFFF_FFFF, 1'b0, none);
    add_row(ccg_pkg::CMD_SAMPLE, 16'h0, 16'h0, 16'h0, 24'h0, 32'h0080_0000, 1'b0, none);
    add_row(ccg_pkg::CMD_CLEAR, 16'h0, 16'h0, 16'h0, 24'h0, 32'h0, 1'b0, none);
    add_row(ccg_pkg::CMD_SAMPLE, 16'h0, 16'h0, 16'h0, 24'h0, 32'h5, 1'b1, NoSegColor);
    add_row(ccg_pkg::CMD_APPEND, 16'h0, 16'hFFFF, 16'h8000, 24'h1, 32'h0, 1'b0, none);
    add_row(ccg_pkg::CMD_SAMPLE, 16'h0, 16'h0, 16'h0, 24'h0, 32'hFFFF_FFFF, 1'b1,
            ccg_pkg::out_beat_t'({16'h0000, ccg_pkg::FullChan, 16'h8000, 1'b0}));
    add_row(ccg_pkg::CMD_APPEND, 16'hFFFF, 16'h0, 16'h0, 24'h3, 32'h0, 1'b0, none);
    add_row(ccg_pkg::CMD_SAMPLE, 16'h0, 16'h0, 16'h0, 24'h0, 32'h2, 1'b0, none);
    add_row(ccg_pkg::CMD_SAMPLE, 16'h0, 16'h0, 16'h0, 24'h0, 32'h1, 1'b1,
            ccg_pkg::out_beat_t'({ccg_pkg::FullChan, 16'h0000, 16'h0000, 1'b0}));
    add_row(ccg_pkg::CMD_CLEAR, 16'h0, 16'h0, 16'h0, 24'h0, 32'h0, 1'b0, none);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (j = 0; j < dir_beats.size(); j++)
      send_cmd(dir_beats[j], dir_typed[j], dir_want[j]);

    items = 0;
    seq = 0;
    while (items < ItemTarget) begin
      if (items >= QuietFrom) begin
        tx_idle = 1'b0;
        rx_idle = 1'b0;
      end else begin
        tx_idle = ($urandom_range(0, 3) != 0);
        rx_idle = ($urandom_range(0, 3) != 0);
      end
      if (seq == 6) hold_output = 1'b1;
      // let the pipe run dry before the next program
      if (items < QuietFrom && (seq == 12 || seq % 50 == 49)) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_colors.size() != 0);
      end

      if (seq == 0 || $urandom_range(0, 9) != 0) begin
        send_cmd(noisy_beat(ccg_pkg::CMD_CLEAR), 1'b0, none);
        items++;
      end

      r = $urandom_range(0, 19);
      if (seq == 0)    n = 66;
      else if (r < 14) n = $urandom_range(1, 6);
      else if (r < 17) n = $urandom_range(7, 20);
      else if (r < 19) n = $urandom_range(60, 70);
      else             n = 0;
      for (j = 0; j < n; j++) begin
        beat = noisy_beat(ccg_pkg::CMD_APPEND);
        beat.node_red   = pick_chan();
        beat.node_green = pick_chan();
        beat.node_blue  = pick_chan();
        case ($urandom_range(0, 9))
          0:       beat.node_span = '0;
          1:       beat.node_span = 24'hFF_FFFF;
          2:       beat.node_span = ccg_pkg::SpanW'($urandom);
          3:       beat.node_span = ccg_pkg::SpanW'($urandom_range(1, 16));
          default: beat.node_span = ccg_pkg::SpanW'($urandom_range(1, 24'h04_0000));
        endcase
        items++;
        send_cmd(beat, 1'b0, none);
      end

      k = $urandom_range(1, 6);
      for (j = 0; j < k; j++) begin
        beat = noisy_beat(ccg_pkg::CMD_SAMPLE);
        tot32 = 32'(tbl_total);
        case ($urandom_range(0, 9))
          0, 1: ;
          2, 3: begin
            if (tbl_count != 0) begin
              n = $urandom_range(0, tbl_count - 1);
              seg_start = 0;
              for (r = 0; r < n; r++) seg_start += 64'(tbl_span[r]);
              seg_start += tbl_total * 64'($urandom_range(0, 3));
              beat.position = ccg_pkg::PosW'(seg_start - 64'($urandom_range(0, 1)));
            end
          end
          default: if (tot32 != 0) beat.position = $urandom_range(0, tot32 - 1);
        endcase
        if ($urandom_range(0, 19) == 0) beat.command = ccg_pkg::cmd_e'(CmdIgnored);
        items++;
        send_cmd(beat, 1'b0, none);
      end
      seq++;
    end

    tx_idle = 1'b0;
    rx_idle = 1'b0;
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_colors.size() != 0);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

### files.f
design/ccg_pkg.sv
design/ccg_div.sv
design/cyclic_color_gradient_sampler_core.sv
tb/tb_cyclic_color_gradient_sampler_core.sv
